[rtl/max_prefix_sum_range_tree_core_assert.svh]
// Assertion macros shared by the range tree modules.
// Both macros sample on the rising edge of clk and are disabled while arst_n is low.
`ifndef MAX_PREFIX_SUM_RANGE_TREE_CORE_ASSERT_SVH
`define MAX_PREFIX_SUM_RANGE_TREE_CORE_ASSERT_SVH
`ifndef SYNTH
`define MPST_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MPST_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define MPST_ASSERT(label, prop, msg)
`define MPST_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

[rtl/mpst_pkg.sv]
`timescale 1ns / 1ps
package mpst_pkg;

	localparam int BEST_W = 42;

	localparam logic       OP_WRITE     = 1'b0;
	localparam logic       OP_QUERY     = 1'b1;

	localparam logic [1:0] STATUS_WRITE = 2'd0;
	localparam logic [1:0] STATUS_QUERY = 2'd1;
	localparam logic [1:0] STATUS_ERROR = 2'd2;

	localparam logic [10:0] USED_LENGTH_RESET = 11'd1024;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       clr;
		logic       load;
		logic       wleaf;
		logic       wstep;
		logic       qstep;
		logic       emit;
		logic [1:0] emit_status;
	} mpst_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic in_op;
		logic in_err;
		logic walk_last;
		logic q_more;
	} mpst_sts_t;

endpackage

[rtl/max_prefix_sum_range_tree_core.sv]
`timescale 1ns / 1ps
// Max prefix sum range tree over LEAVES signed 32-bit elements, all zero at reset.
// Input channel: an item is taken at a rising edge where start is high and busy is low.
// opcode selects a write of value at first_index, or a query of the largest prefix sum
// (never below zero) of elements first_index through last_index.
// Result channel: done is high for exactly one cycle with status and best_prefix;
// the receiver cannot stall, so it must take every result in that cycle.
// Configuration: used_length is written whenever used_length_we is high. The user must
// write it only while idle; the block itself does not enforce this rule.
// A write stores the leaf, then walks one tree level per cycle through the node memory,
// and its result strobes once the root is written. A query steps both range ends up one
// level per cycle, two memory reads a cycle, and strobes once the ends meet. An item
// with a bad index or range is answered with the error status in the very next cycle.
// One item is in work at a time; busy drops in the cycle the result strobes.
// After reset the node memory is cleared one entry a cycle, which keeps busy high
// through that pass; configuration writes are taken during that pass.
module max_prefix_sum_range_tree_core
	import mpst_pkg::*;
#(
	parameter int LEAVES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [9:0]         first_index,
	input  logic [9:0]         last_index,
	input  logic signed [31:0] value,
	input  logic               used_length_we,
	input  logic [10:0]        used_length,
	output logic               done,
	output logic [1:0]         status,
	output logic [BEST_W-1:0]  best_prefix
);

	mpst_cmd_t cmd;
	mpst_sts_t sts;

	// The controller sequences clear, write walk and query walk.
	mpst_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	// The datapath holds the node memory, walk indices and accumulators.
	mpst_dp #(
		.LEAVES(LEAVES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.first_index   (first_index),
		.last_index    (last_index),
		.value         (value),
		.used_length_we(used_length_we),
		.used_length   (used_length),
		.done          (done),
		.status        (status),
		.best_prefix   (best_prefix)
	);

endmodule

[rtl/mpst_ram.sv]
`timescale 1ns / 1ps
module mpst_ram #(
	parameter int WIDTH = 84,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

[rtl/mpst_ctrl.sv]
`timescale 1ns / 1ps
`include "max_prefix_sum_range_tree_core_assert.svh"
module mpst_ctrl
	import mpst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  mpst_sts_t sts,
	output mpst_cmd_t cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_WLEAF = 3'd2;
	localparam logic [2:0] ST_WSTEP = 3'd3;
	localparam logic [2:0] ST_QWALK = 3'd4;
	localparam logic [2:0] ST_QFIN  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (sts.in_err) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = STATUS_ERROR;
					end else begin
						cmd.load = 1'b1;
						state_d  = (sts.in_op == OP_QUERY) ? ST_QWALK : ST_WLEAF;
					end
				end
			end
			ST_WLEAF: begin
				cmd.wleaf = 1'b1;
				state_d   = ST_WSTEP;
			end
			ST_WSTEP: begin
				cmd.wstep = 1'b1;
				if (sts.walk_last) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = STATUS_WRITE;
					state_d         = ST_IDLE;
				end
			end
			ST_QWALK: begin
				cmd.qstep = 1'b1;
				if (!sts.q_more) begin
					state_d = ST_QFIN;
				end
			end
			ST_QFIN: begin
				cmd.emit        = 1'b1;
				cmd.emit_status = STATUS_QUERY;
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	`MPST_ASSERT_NEXT(a_load_goes_busy, state_q == ST_IDLE && start && !sts.in_err, state_q != ST_IDLE, "accepted item did not start a walk")
	`MPST_ASSERT_NEXT(a_walk_ends_idle, state_q == ST_WSTEP && sts.walk_last, state_q == ST_IDLE, "write walk did not finish at the root")
	`MPST_ASSERT(a_emit_states, cmd.emit |-> (state_q == ST_IDLE || state_q == ST_WSTEP || state_q == ST_QFIN), "result emitted from a working state")

endmodule

[rtl/mpst_dp.sv]
`timescale 1ns / 1ps
`include "max_prefix_sum_range_tree_core_assert.svh"
module mpst_dp
	import mpst_pkg::*;
#(
	parameter int LEAVES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mpst_cmd_t          cmd,
	output mpst_sts_t          sts,
	input  logic               opcode,
	input  logic [9:0]         first_index,
	input  logic [9:0]         last_index,
	input  logic signed [31:0] value,
	input  logic               used_length_we,
	input  logic [10:0]        used_length,
	output logic               done,
	output logic [1:0]         status,
	output logic [BEST_W-1:0]  best_prefix
);

	localparam int NW    = $clog2(2 * LEAVES);
	localparam int SW    = 32 + $clog2(LEAVES);
	localparam int XW    = (SW > BEST_W) ? SW : BEST_W;
	localparam int DEPTH = 2 * LEAVES;
	localparam logic [NW-1:0] CLR_LAST = NW'(DEPTH - 1);
	localparam logic [NW-1:0] ROOT     = NW'(1);
	localparam logic [31:0]   LEAVES_W = 32'(LEAVES);

	logic [10:0]          used_len_q;
	logic [NW-1:0]        clr_cnt_q;
	logic [NW-1:0]        lo_q;
	logic [NW:0]          hi_q;
	logic signed [SW-1:0] val_q;
	logic signed [SW-1:0] cur_sum_q;
	logic signed [SW-1:0] cur_best_q;
	logic signed [SW-1:0] ls_q;
	logic signed [SW-1:0] lb_q;
	logic signed [SW-1:0] rb_q;
	logic                 vld_s1;
	logic                 tl_s1;
	logic                 tr_s1;
	logic                 done_q;
	logic [1:0]           status_q;
	logic [BEST_W-1:0]    best_q;

	logic                 ram_we;
	logic [NW-1:0]        ram_waddr;
	logic [2*SW-1:0]      ram_wdata;
	logic [NW-1:0]        raddr_a;
	logic [NW-1:0]        raddr_b;
	logic [2*SW-1:0]      rdata_a;
	logic [2*SW-1:0]      rdata_b;

	logic signed [SW-1:0] sum_a, best_a, sum_b, best_b;
	logic signed [SW-1:0] l_sum, l_best, r_sum, r_best;
	logic signed [SW-1:0] res_sum, res_best, res_t;
	logic signed [SW-1:0] ql_t, qr_t, tot, ans;
	logic [SW-1:0]        ans_pos;
	logic [XW-1:0]        ans_ext;
	logic [NW-1:0]        parent;
	logic                 wr_err, qr_err;

	// Index checks against the used length and the tree size.
	always_comb begin
		wr_err = ({1'b0, first_index} >= used_len_q) || (32'(first_index) >= LEAVES_W);
		qr_err = (first_index > last_index) || ({1'b0, last_index} >= used_len_q) ||
			(32'(last_index) >= LEAVES_W);
	end

	assign parent = lo_q >> 1;

	assign sts.clr_done  = (clr_cnt_q == CLR_LAST);
	assign sts.in_op     = opcode;
	assign sts.in_err    = (opcode == OP_QUERY) ? qr_err : wr_err;
	assign sts.walk_last = (parent == ROOT);
	assign sts.q_more    = ({1'b0, lo_q} < hi_q);

	assign sum_a  = rdata_a[2*SW-1:SW];
	assign best_a = rdata_a[SW-1:0];
	assign sum_b  = rdata_b[2*SW-1:SW];
	assign best_b = rdata_b[SW-1:0];

	// Parent update: the held child and its sibling, ordered by the child's side.
	always_comb begin
		if (lo_q[0]) begin
			l_sum  = sum_a;
			l_best = best_a;
			r_sum  = cur_sum_q;
			r_best = cur_best_q;
		end else begin
			l_sum  = cur_sum_q;
			l_best = cur_best_q;
			r_sum  = sum_a;
			r_best = best_a;
		end
		res_sum  = l_sum + r_sum;
		res_t    = l_sum + r_best;
		res_best = (l_best > res_t) ? l_best : res_t;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = lo_q;
		ram_wdata = {val_q, val_q};
		if (cmd.clr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else if (cmd.wleaf) begin
			ram_we    = 1'b1;
		end else if (cmd.wstep) begin
			ram_we    = 1'b1;
			ram_waddr = parent;
			ram_wdata = {res_sum, res_best};
		end
	end

	always_comb begin
		if (cmd.wleaf) begin
			raddr_a = lo_q ^ ROOT;
		end else if (cmd.wstep) begin
			raddr_a = parent ^ ROOT;
		end else begin
			raddr_a = lo_q;
		end
		raddr_b = NW'(hi_q - 1'b1);
	end

	mpst_ram #(
		.WIDTH(2 * SW),
		.DEPTH(DEPTH)
	) u_node_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	// Query accumulators and the final answer.
	always_comb begin
		ql_t    = ls_q + best_a;
		qr_t    = sum_b + rb_q;
		tot     = ls_q + rb_q;
		ans     = (lb_q > tot) ? lb_q : tot;
		ans_pos = ans[SW-1] ? '0 : ans;
		ans_ext = XW'(ans_pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_len_q <= USED_LENGTH_RESET;
			clr_cnt_q  <= '0;
			vld_s1     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (used_length_we) begin
				used_len_q <= used_length;
			end
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			vld_s1 <= cmd.qstep && sts.q_more;
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q  <= NW'(LEAVES_W + 32'(first_index));
			hi_q  <= (NW+1)'(LEAVES_W + 32'(last_index) + 32'd1);
			val_q <= SW'(value);
			ls_q  <= '0;
			lb_q  <= '0;
			rb_q  <= '0;
		end else if (cmd.wleaf) begin
			cur_sum_q  <= val_q;
			cur_best_q <= val_q;
		end else if (cmd.wstep) begin
			cur_sum_q  <= res_sum;
			cur_best_q <= res_best;
			lo_q       <= parent;
		end else if (cmd.qstep && sts.q_more) begin
			lo_q <= NW'(({1'b0, lo_q} + {{NW{1'b0}}, lo_q[0]}) >> 1);
			hi_q <= hi_q >> 1;
		end
		if (cmd.qstep) begin
			tl_s1 <= lo_q[0];
			tr_s1 <= hi_q[0];
		end
		if (vld_s1 && !cmd.load) begin
			if (tl_s1) begin
				lb_q <= (lb_q > ql_t) ? lb_q : ql_t;
				ls_q <= ls_q + sum_a;
			end
			if (tr_s1) begin
				rb_q <= (best_b > qr_t) ? best_b : qr_t;
			end
		end
		if (cmd.emit) begin
			status_q <= cmd.emit_status;
			best_q   <= (cmd.emit_status == STATUS_QUERY) ? ans_ext[BEST_W-1:0] : '0;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign best_prefix = best_q;

	`MPST_ASSERT(a_best_zero, (done_q && status_q != STATUS_QUERY) |-> (best_q == '0), "nonzero best prefix on a non-query result")
	`MPST_ASSERT(a_vld_from_step, vld_s1 |-> $past(cmd.qstep), "query combine without a tree step")

endmodule
